// File: sv/cpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// shared constants, command and status types and the crc byte update
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;
  localparam int unsigned HDR_LEN     = 8;
  localparam int unsigned CNT_W       = 13;

  localparam logic [7:0]  SYNC_A      = 8'h47;
  localparam logic [7:0]  SYNC_B      = 8'h4D;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd50;
  localparam logic [7:0]  VERSION_RST = 8'd1;

  // register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  // event codes
  localparam logic [2:0] EV_OK        = 3'd0;
  localparam logic [2:0] EV_CRC_ERR   = 3'd1;
  localparam logic [2:0] EV_REJECT    = 3'd2;
  localparam logic [2:0] EV_RETX_REQ  = 3'd3;
  localparam logic [2:0] EV_RETX_GIVE = 3'd4;

  // header fault codes
  localparam logic [1:0] FLT_NONE    = 2'd0;
  localparam logic [1:0] FLT_VERSION = 2'd1;
  localparam logic [1:0] FLT_TYPE    = 2'd2;
  localparam logic [1:0] FLT_LENGTH  = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LATCH  = 4'd1;
  localparam logic [3:0] OP_TICK   = 4'd2;
  localparam logic [3:0] OP_APPEND = 4'd3;
  localparam logic [3:0] OP_BODY   = 4'd4;
  localparam logic [3:0] OP_SHIFT  = 4'd5;
  localparam logic [3:0] OP_JUDGE  = 4'd6;
  localparam logic [3:0] OP_CRC    = 4'd7;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] crc_idx;
    logic       load_out;
  } cpd_cmd_t;

  typedef struct packed {
    logic func;
    logic hdr_full;
    logic cnt_lt2;
    logic cnt_eq8;
    logic magic_front;
    logic hdr_bad;
    logic res_pend;
    logic out_free;
  } cpd_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: sv/cpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_ctrl
// sequencer: dispatch, magic rescan, header judge, header crc, result hand-off
// ----------------------------------------------------------------------------
module cpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpd_pkg::cpd_sts_t sts,
  output cpd_pkg::cpd_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_JUDGE = 3'd3;
  localparam logic [2:0] ST_CRC   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd.op       = cpd_pkg::OP_NONE;
    cmd.crc_idx  = idx_r;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = cpd_pkg::OP_LATCH;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        priority if (sts.func) begin
          cmd.op    = cpd_pkg::OP_TICK;
          state_nxt = ST_FIN;
        end else if (!sts.hdr_full) begin
          cmd.op    = cpd_pkg::OP_APPEND;
          state_nxt = ST_SCAN;
        end else begin
          cmd.op    = cpd_pkg::OP_BODY;
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        priority if (sts.cnt_lt2) begin
          state_nxt = ST_FIN;
        end else if (sts.magic_front) begin
          state_nxt = sts.cnt_eq8 ? ST_JUDGE : ST_FIN;
        end else begin
          cmd.op = cpd_pkg::OP_SHIFT;
        end
      end
      ST_JUDGE: begin
        cmd.op  = cpd_pkg::OP_JUDGE;
        idx_nxt = '0;
        state_nxt = sts.hdr_bad ? ST_SCAN : ST_CRC;
      end
      ST_CRC: begin
        cmd.op  = cpd_pkg::OP_CRC;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'(cpd_pkg::HDR_LEN - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        priority if (!sts.res_pend) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: sv/cpd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_dp
// header store, counters, crc register, timers and result registers
// ----------------------------------------------------------------------------
module cpd_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  cpd_pkg::cpd_cmd_t cmd,
  output cpd_pkg::cpd_sts_t sts,
  input  logic              in_func,
  input  logic [7:0]        in_data_byte,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_event_res,
  output logic [1:0]        out_header_fault,
  output logic [2:0]        out_packet_type,
  output logic [15:0]       out_sequence_res,
  output logic [12:0]       out_payload_length,
  output logic              out_needs_response
);

  localparam int CW = cpd_pkg::CNT_W;

  logic [7:0]    store_r [cpd_pkg::HDR_LEN];
  logic [CW-1:0] count_r;
  logic [15:0]   crc_r;
  logic [7:0]    trl_lo_r;
  logic [15:0]   last_seq_r;
  logic [CW-1:0] cur_len_r;
  logic          waiting_r;
  logic [15:0]   elapsed_r;
  logic [15:0]   timeout_r;
  logic [7:0]    version_r;
  logic          func_r;
  logic [7:0]    byte_r;
  logic          res_pend_r;
  logic [2:0]    res_ev_r;
  logic [1:0]    res_flt_r;
  logic [2:0]    res_type_r;
  logic [15:0]   res_seq_r;
  logic [12:0]   res_len_r;
  logic          res_resp_r;
  logic          out_valid_r;
  logic [2:0]    o_ev_r;
  logic [1:0]    o_flt_r;
  logic [2:0]    o_type_r;
  logic [15:0]   o_seq_r;
  logic [12:0]   o_len_r;
  logic          o_resp_r;

  logic [15:0]   e_inc;
  logic [15:0]   hdr_seq, hdr_len, rx_crc;
  logic [7:0]    hdr_type;
  logic [1:0]    fault;
  logic [CW-1:0] body_end;
  logic          drop_all;

  assign e_inc    = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign hdr_type = store_r[3];
  assign hdr_seq  = {store_r[5], store_r[4]};
  assign hdr_len  = {store_r[7], store_r[6]};
  assign rx_crc   = {byte_r, trl_lo_r};
  assign body_end = CW'(cpd_pkg::HDR_LEN) + cur_len_r;

  always_comb begin
    priority if (store_r[2] != version_r) fault = cpd_pkg::FLT_VERSION;
    else if (hdr_type < 8'd1 || hdr_type > 8'd4) fault = cpd_pkg::FLT_TYPE;
    else if (hdr_len > 16'(cpd_pkg::MAX_PAYLOAD)) fault = cpd_pkg::FLT_LENGTH;
    else fault = cpd_pkg::FLT_NONE;
  end

  // two bytes left without a pair: keep the tail only if it can open one
  assign drop_all = (count_r == CW'(2)) && (store_r[1] != cpd_pkg::SYNC_A);

  assign sts.func        = func_r;
  assign sts.hdr_full    = (count_r >= CW'(cpd_pkg::HDR_LEN));
  assign sts.cnt_lt2     = (count_r < CW'(2));
  assign sts.cnt_eq8     = (count_r == CW'(cpd_pkg::HDR_LEN));
  assign sts.magic_front = (store_r[0] == cpd_pkg::SYNC_A) && (store_r[1] == cpd_pkg::SYNC_B);
  assign sts.hdr_bad     = (fault != cpd_pkg::FLT_NONE);
  assign sts.res_pend    = res_pend_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  // header store, no reset
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      cpd_pkg::OP_APPEND: store_r[count_r[2:0]] <= byte_r;
      cpd_pkg::OP_SHIFT, cpd_pkg::OP_JUDGE: begin
        if (cmd.op == cpd_pkg::OP_SHIFT || fault != cpd_pkg::FLT_NONE) begin
          for (int i = 0; i < cpd_pkg::HDR_LEN - 1; i++) store_r[i] <= store_r[i+1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= cpd_pkg::CRC_INIT;
      trl_lo_r    <= '0;
      last_seq_r  <= '0;
      cur_len_r   <= '0;
      waiting_r   <= 1'b0;
      elapsed_r   <= '0;
      timeout_r   <= cpd_pkg::TIMEOUT_RST;
      version_r   <= cpd_pkg::VERSION_RST;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cpd_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata;
          cpd_pkg::REG_VERSION: version_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        res_pend_r  <= 1'b0;
        o_ev_r      <= res_ev_r;
        o_flt_r     <= res_flt_r;
        o_type_r    <= res_type_r;
        o_seq_r     <= res_seq_r;
        o_len_r     <= res_len_r;
        o_resp_r    <= res_resp_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (cmd.op)
        cpd_pkg::OP_LATCH: begin
          func_r     <= in_func;
          byte_r     <= in_data_byte;
          res_pend_r <= 1'b0;
        end
        cpd_pkg::OP_TICK: begin
          res_flt_r  <= cpd_pkg::FLT_NONE;
          res_type_r <= '0;
          res_len_r  <= '0;
          res_resp_r <= 1'b0;
          if (waiting_r) begin
            if (e_inc >= timeout_r) begin
              count_r    <= '0;
              last_seq_r <= '0;
              waiting_r  <= 1'b0;
              elapsed_r  <= '0;
              res_pend_r <= 1'b1;
              res_ev_r   <= cpd_pkg::EV_RETX_GIVE;
              res_seq_r  <= '0;
            end else begin
              elapsed_r <= e_inc;
            end
          end else if (count_r != '0) begin
            if (e_inc >= timeout_r) begin
              count_r    <= '0;
              waiting_r  <= 1'b1;
              elapsed_r  <= '0;
              res_pend_r <= 1'b1;
              res_ev_r   <= cpd_pkg::EV_RETX_REQ;
              res_seq_r  <= last_seq_r;
            end else begin
              elapsed_r <= e_inc;
            end
          end
        end
        cpd_pkg::OP_APPEND: begin
          if (count_r == '0 && !waiting_r) elapsed_r <= '0;
          count_r <= count_r + CW'(1);
        end
        cpd_pkg::OP_SHIFT: begin
          count_r <= drop_all ? '0 : count_r - CW'(1);
        end
        cpd_pkg::OP_JUDGE: begin
          if (fault != cpd_pkg::FLT_VERSION && fault != cpd_pkg::FLT_TYPE)
            last_seq_r <= hdr_seq;
          if (fault != cpd_pkg::FLT_NONE) begin
            count_r    <= count_r - CW'(1);
            res_pend_r <= 1'b1;
            res_ev_r   <= cpd_pkg::EV_REJECT;
            res_flt_r  <= fault;
            res_type_r <= (fault == cpd_pkg::FLT_LENGTH) ? hdr_type[2:0] : 3'd0;
            res_seq_r  <= (fault == cpd_pkg::FLT_LENGTH) ? hdr_seq : 16'd0;
            res_len_r  <= '0;
            res_resp_r <= 1'b0;
          end else begin
            cur_len_r <= hdr_len[CW-1:0];
            crc_r     <= cpd_pkg::CRC_INIT;
          end
        end
        cpd_pkg::OP_CRC: begin
          crc_r <= cpd_pkg::crc_byte(crc_r, store_r[cmd.crc_idx]);
        end
        cpd_pkg::OP_BODY: begin
          priority if (count_r < body_end) begin
            count_r <= count_r + CW'(1);
            crc_r   <= cpd_pkg::crc_byte(crc_r, byte_r);
          end else if (count_r == body_end) begin
            count_r  <= count_r + CW'(1);
            trl_lo_r <= byte_r;
          end else begin
            count_r    <= '0;
            res_pend_r <= 1'b1;
            res_flt_r  <= cpd_pkg::FLT_NONE;
            res_type_r <= hdr_type[2:0];
            res_seq_r  <= hdr_seq;
            res_len_r  <= cur_len_r;
            if (rx_crc == crc_r) begin
              waiting_r  <= 1'b0;
              res_ev_r   <= cpd_pkg::EV_OK;
              res_resp_r <= (hdr_type == 8'd1);
            end else begin
              res_ev_r   <= cpd_pkg::EV_CRC_ERR;
              res_resp_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = o_ev_r;
  assign out_header_fault   = o_flt_r;
  assign out_packet_type    = o_type_r;
  assign out_sequence_res   = o_seq_r;
  assign out_payload_length = o_len_r;
  assign out_needs_response = o_resp_r;

endmodule

// File: sv/crc16_packet_deframer_with_timeout_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_deframer_with_timeout_top
// byte stream deframer with crc-16/modbus check and millisecond timeouts
// ----------------------------------------------------------------------------
// each input word is either a received byte or a millisecond tick. the block
// hunts for the magic pair 0x47 0x4d, gathers an 8-byte header, checks
// version, type and length, then runs crc-16/modbus over header and payload
// and compares it with the little-endian trailer. results: packet ok, crc
// error, header rejected, retransmit request and retransmit give-up. a word is
// latched, dispatched and finished before the next is taken; a header byte is
// appended and the store rescanned for magic, shifting out bytes that cannot
// start it; a full header is then checked and either run through the crc byte
// update, one byte per cycle, or, on rejection, shifted by one byte and
// rescanned. a result sits in an output register, so the next word is taken
// while it waits; a second result waits in the finish state until it is free.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_with_timeout_top (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [1:0]  out_header_fault,
  output logic [2:0]  out_packet_type,
  output logic [15:0] out_sequence_res,
  output logic [12:0] out_payload_length,
  output logic        out_needs_response,
  // configuration: index 0 timeout ticks, index 1 expected version
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  cpd_pkg::cpd_cmd_t cmd;
  cpd_pkg::cpd_sts_t sts;

  // sequencer
  cpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // header store, crc, timers and output register
  cpd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_data_byte       (in_data_byte),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_header_fault   (out_header_fault),
    .out_packet_type    (out_packet_type),
    .out_sequence_res   (out_sequence_res),
    .out_payload_length (out_payload_length),
    .out_needs_response (out_needs_response)
  );

endmodule

// File: sv/cpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module cpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_res,
  input logic [1:0]  out_header_fault,
  input logic [2:0]  out_packet_type,
  input logic        out_needs_response
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res))
    else $error("result word dropped or changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= cpd_pkg::EV_RETX_GIVE)
    else $error("event code out of range");

  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != cpd_pkg::EV_REJECT |-> out_header_fault == 2'd0)
    else $error("fault code outside rejection");

  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_needs_response |->
      out_event_res == cpd_pkg::EV_OK && out_packet_type == 3'd1)
    else $error("response flag on non-command or bad packet");

endmodule

bind crc16_packet_deframer_with_timeout_top cpd_checker u_cpd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_event_res      (out_event_res),
  .out_header_fault   (out_header_fault),
  .out_packet_type    (out_packet_type),
  .out_needs_response (out_needs_response)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed test of the crc-16 packet deframer with timeouts
// ----------------------------------------------------------------------------
// words (bytes and ticks) go in over valid/ready, a model of the deframer
// predicts each event, and a scoreboard compares every result in all its fields.
// ----------------------------------------------------------------------------

class deframer_board;
  typedef struct packed {
    logic [2:0]  ev;
    logic [1:0]  fault;
    logic [2:0]  ptype;
    logic [15:0] seq;
    logic [12:0] len;
    logic        resp;
  } event_t;

  logic [7:0]  hdr [8];
  int unsigned cnt;
  logic [15:0] crc;
  logic [7:0]  trl_lo;
  logic [15:0] last_seq;
  int unsigned cur_len;
  bit          waiting;
  logic [15:0] ticks;
  logic [15:0] timeout;
  logic [7:0]  version;
  event_t      pending[$];
  int          errors;

  function new();
    cnt = 0; crc = 16'hFFFF; trl_lo = 0; last_seq = 0; cur_len = 0;
    waiting = 0; ticks = 0; timeout = 16'd50; version = 8'd1; errors = 0;
    foreach (hdr[i]) hdr[i] = 0;
  endfunction

  function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function void push(logic [2:0] ev, logic [1:0] f, logic [2:0] t,
                     logic [15:0] s, logic [12:0] l, logic r);
    event_t e;
    e.ev = ev; e.fault = f; e.ptype = t; e.seq = s; e.len = l; e.resp = r;
    pending.push_back(e);
  endfunction

  function void drop(int unsigned n);
    if (n >= cnt) begin
      cnt = 0;
      return;
    end
    for (int i = 0; i < cnt - n; i++) hdr[i] = hdr[i + n];
    cnt -= n;
  endfunction

  // hunt for magic in the buffered header bytes, judge a full header
  function void hunt();
    int unsigned m;
    logic [1:0] f;
    logic [7:0] t;
    logic [15:0] s;
    int unsigned l;
    forever begin
      if (cnt < 2) return;
      m = 0;
      while (m + 1 < cnt && !(hdr[m] == 8'h47 && hdr[m + 1] == 8'h4D)) m++;
      if (m + 1 >= cnt) begin
        if (hdr[cnt - 1] == 8'h47) begin
          hdr[0] = 8'h47;
          cnt = 1;
        end else cnt = 0;
        return;
      end
      if (m > 0) drop(m);
      if (cnt < 8) return;
      t = hdr[3]; f = 2'd0; s = 16'd0; l = 0;
      if (hdr[2] != version) f = 2'd1;
      else if (t < 1 || t > 4) f = 2'd2;
      else begin
        s = {hdr[5], hdr[4]};
        last_seq = s;
        l = {hdr[7], hdr[6]};
        if (l > 4096) f = 2'd3;
      end
      if (f != 0) begin
        push(3'd2, f, f == 3 ? t[2:0] : 3'd0, f == 3 ? s : 16'd0, 13'd0, 1'b0);
        drop(1);
        continue;
      end
      cur_len = l;
      crc = 16'hFFFF;
      for (int i = 0; i < 8; i++) crc = crc_step(crc, hdr[i]);
      return;
    end
  endfunction

  function void note_word(bit func, logic [7:0] b);
    logic [15:0] rx;
    if (func) begin
      if (waiting) begin
        if (ticks != 16'hFFFF) ticks++;
        if (ticks >= timeout) begin
          cnt = 0; last_seq = 0; waiting = 0; ticks = 0;
          push(3'd4, 2'd0, 3'd0, 16'd0, 13'd0, 1'b0);
        end
        return;
      end
      if (cnt == 0) return;
      if (ticks != 16'hFFFF) ticks++;
      if (ticks < timeout) return;
      cnt = 0; waiting = 1; ticks = 0;
      push(3'd3, 2'd0, 3'd0, last_seq, 13'd0, 1'b0);
      return;
    end
    if (cnt == 0 && !waiting) ticks = 0;
    if (cnt < 8) begin
      hdr[cnt] = b;
      cnt++;
      hunt();
    end else begin
      if (cnt < 8 + cur_len) crc = crc_step(crc, b);
      else if (cnt == 8 + cur_len) trl_lo = b;
      else begin
        rx = {b, trl_lo};
        cnt = 0;
        if (rx == crc) begin
          waiting = 0;
          push(3'd0, 2'd0, hdr[3][2:0], {hdr[5], hdr[4]}, cur_len[12:0], hdr[3] == 1);
        end else push(3'd1, 2'd0, hdr[3][2:0], {hdr[5], hdr[4]}, cur_len[12:0], 1'b0);
        cnt = 0;
        return;
      end
      cnt++;
    end
  endfunction

  function void check_event(event_t got);
    event_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $write("mismatch: exp ev %0d flt %0d typ %0d seq %h len %0d rsp %0d",
               want.ev, want.fault, want.ptype, want.seq, want.len, want.resp);
        $display(" / got ev %0d flt %0d typ %0d seq %h len %0d rsp %0d",
                 got.ev, got.fault, got.ptype, got.seq, got.len, got.resp);
      end
    end
  endfunction
endclass

module tb_top;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_func = 0;
  logic [7:0]  in_data_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_event_res;
  logic [1:0]  out_header_fault;
  logic [2:0]  out_packet_type;
  logic [15:0] out_sequence_res;
  logic [12:0] out_payload_length;
  logic        out_needs_response;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_wdata = 0;

  int send_idle = 0;   // percent of cycles the sender holds off
  int recv_idle = 0;   // percent of cycles the receiver stalls
  int random_words = 0;

  deframer_board board = new();

  crc16_packet_deframer_with_timeout_top dut (.*);

  always #5 clk = ~clk;

  // receiver: random stalls, check on every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_event({out_event_res, out_header_fault, out_packet_type,
                         out_sequence_res, out_payload_length, out_needs_response});
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // one word through the handshake, with a random hold-off first;
  // valid stays high after acceptance so back-to-back words need no gap
  task automatic send_word(bit func, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_func <= func; in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(func, b);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(1'b0, b);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] v);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == cpd_pkg::REG_TIMEOUT) board.timeout = v;
    else board.version = v[7:0];
  endtask

  // a whole frame, or only its header if it will be rejected; bad_crc flips one trailer bit
  task automatic send_frame(logic [7:0] ver, logic [7:0] typ, logic [15:0] seq,
                            int unsigned len, bit bad_crc);
    logic [7:0] h [8];
    logic [15:0] c;
    logic [7:0] p;
    h[0] = cpd_pkg::SYNC_A; h[1] = cpd_pkg::SYNC_B; h[2] = ver; h[3] = typ;
    h[4] = seq[7:0]; h[5] = seq[15:8]; h[6] = len[7:0]; h[7] = len[15:8];
    c = 16'hFFFF;
    for (int i = 0; i < 8; i++) begin
      send_byte(h[i]);
      c = board.crc_step(c, h[i]);
    end
    if (len > 4096 || ver != board.version || typ < 1 || typ > 4) return;
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom);
      send_byte(p);
      c = board.crc_step(c, p);
    end
    if (bad_crc) c = c ^ (16'h1 << $urandom_range(15));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  task automatic random_phase(int words);
    int r;
    random_words = 0;
    while (random_words < words) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_frame($urandom_range(9) == 0 ? 8'($urandom) : board.version,
                   $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(1, 4)),
                   16'($urandom),
                   $urandom_range(9) == 0 ? $urandom_range(4090, 65535)
                                          : $urandom_range(0, 12),
                   $urandom_range(4) == 0);
        random_words += 14;
      end else if (r < 80) begin
        send_word(1'b1, 8'($urandom));
        random_words++;
      end else if (r < 90) begin
        repeat ($urandom_range(1, 12)) send_word(1'b1, 8'($urandom));
        random_words += 6;
      end else begin
        send_byte($urandom_range(1) ? 8'h47 : 8'($urandom));
        random_words++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes of the fields, all types and faults
    send_frame(8'd1, 8'd1, 16'h0000, 0, 0);
    send_frame(8'd1, 8'd2, 16'hFFFF, 3, 0);
    send_frame(8'd1, 8'd3, 16'h1234, 1, 1);
    send_frame(8'd1, 8'd4, 16'hA5A5, 2, 0);
    send_frame(8'd2, 8'd1, 16'h0001, 0, 0);       // version fault
    send_frame(8'd1, 8'd0, 16'h0002, 0, 0);       // type fault
    send_frame(8'd1, 8'd7, 16'h0003, 0, 0);
    send_frame(8'd1, 8'd1, 16'h0004, 4097, 0);    // length fault, seq captured
    send_byte(8'h47); send_byte(8'h47); send_byte(8'h4D); // trailing magic kept
    send_byte(8'h00); send_byte(8'hFF);
    drain();

    // zero timeout: the first tick requests a retransmit, the second gives up
    write_reg(cpd_pkg::REG_TIMEOUT, 16'd0);
    send_byte(8'h12);               // stray byte stays buffered
    send_word(1'b1, 8'hFF);
    send_word(1'b1, 8'h00);
    write_reg(cpd_pkg::REG_TIMEOUT, 16'd3);
    write_reg(cpd_pkg::REG_VERSION, 16'd0);
    // largest payload length passes the header check, then times out
    send_byte(cpd_pkg::SYNC_A); send_byte(cpd_pkg::SYNC_B);
    send_byte(8'h00); send_byte(8'h01); send_byte(8'h55); send_byte(8'h55);
    send_byte(8'h00); send_byte(8'h10);
    repeat (3) send_word(1'b1, 8'h00);
    send_byte(8'h47); repeat (4) send_word(1'b1, 8'h00);
    send_frame(8'd0, 8'd2, 16'h7777, 1, 0);       // good packet after the give-up
    repeat (4) send_word(1'b1, 8'h00);

    // random phases with idle patterns and settings
    send_idle = 19; recv_idle = 73;
    write_reg(cpd_pkg::REG_VERSION, 16'h00FF);
    write_reg(cpd_pkg::REG_TIMEOUT, 16'd2);
    random_phase(500);
    drain();   // sender pauses until all results are in
    send_idle = 73; recv_idle = 19;
    write_reg(cpd_pkg::REG_VERSION, 16'd1);
    write_reg(cpd_pkg::REG_TIMEOUT, 16'd5);
    random_phase(500);
    send_idle = 0; recv_idle = 0;
    write_reg(cpd_pkg::REG_TIMEOUT, 16'hFFFF);
    write_reg(cpd_pkg::REG_VERSION, 16'h0080);
    random_phase(250);
    write_reg(cpd_pkg::REG_TIMEOUT, 16'd1);
    random_phase(250);

    drain();
    if (board.errors == 0)
      $display("crc16_packet_deframer_with_timeout_top verification clean");
    else
      $display("crc16_packet_deframer_with_timeout_top verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("crc16_packet_deframer_with_timeout_top verification failed");
    $finish;
  end
endmodule
